### rtl/core/brc_pkg.sv
// -----------------------------------------------------------------------------
// brc_pkg
// Shared types, constants and divider step functions for the barometer
// reading compensation pipeline.
// -----------------------------------------------------------------------------
package brc_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_CAL_A = 2'd0,
		CFG_CAL_B = 2'd1,
		CFG_CAL_C = 2'd2,
		CFG_OSS   = 2'd3
	} cfg_idx_t;

	// result status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_BAD_CAL = 2'd1;
	localparam logic [1:0] STAT_DIV0    = 2'd2;

	localparam int DIVA_BITS = 27;   // |MC| * 2048 quotient bits
	localparam int DIVB_BITS = 32;   // pressure quotient bits
	localparam int STAGES    = 25 + DIVA_BITS + DIVB_BITS;

	localparam logic [1:0]  OSS_RESET   = 2'd3;
	localparam logic [11:0] T_OFFSET    = 12'd4000;
	localparam logic [11:0] P_SQ_COEF   = 12'd3038;
	localparam logic [12:0] P_LIN_COEF  = 13'd7357;
	localparam logic [11:0] P_OFFSET    = 12'd3791;
	localparam logic [16:0] B7_SCALE    = 17'd50000;
	localparam logic [31:0] B4_BIAS     = 32'd32768;
	localparam logic [17:0] P_MAX       = 18'h3FFFF;

	// temperature divider: rem/dvs wide enough for |X1 + MD|
	typedef struct packed {
		logic [19:0]        rem;
		logic [26:0]        num;
		logic [19:0]        dvs;
		logic               neg;
		logic signed [19:0] x1;
		logic [18:0]        up;
		logic               bad;
		logic               denz;
	} diva_t;

	// pressure divider, B4 is 17 bits
	typedef struct packed {
		logic [16:0] rem;
		logic [31:0] num;
		logic [16:0] dvs;
		logic        big;
		logic [15:0] temp;
		logic        bad;
		logic        denz;
		logic        b4z;
	} divb_t;

	function automatic logic bad_coef(input logic [15:0] w);
		return (w == 16'h0000) || (w == 16'hFFFF);
	endfunction

	// one restoring step, quotient bits shift into num
	function automatic diva_t diva_step(input diva_t d);
		diva_t       r;
		logic [20:0] trial;
		logic        ge;
		r     = d;
		trial = {d.rem, d.num[26]};
		ge    = trial >= {1'b0, d.dvs};
		r.rem = ge ? 20'(trial - {1'b0, d.dvs}) : trial[19:0];
		r.num = {d.num[25:0], ge};
		return r;
	endfunction

	function automatic divb_t divb_step(input divb_t d);
		divb_t       r;
		logic [17:0] trial;
		logic        ge;
		r     = d;
		trial = {d.rem, d.num[31]};
		ge    = trial >= {1'b0, d.dvs};
		r.rem = ge ? 17'(trial - {1'b0, d.dvs}) : trial[16:0];
		r.num = {d.num[30:0], ge};
		return r;
	endfunction

endpackage

### rtl/core/barometer_reading_compensation_unit.sv
// -----------------------------------------------------------------------------
// barometer_reading_compensation_unit
// Integer temperature and pressure compensation of raw barometer readings.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one raw temperature word and
//   the three raw pressure bytes. Output channel (out_valid/out_stall)
//   returns temperature in 0.1 degree, pressure in Pa and a status code.
//   Calibration words and oversampling are written through cfg_we,
//   cfg_index, cfg_data; the user must do so while no reading is in
//   flight, which the block itself does not enforce. The pipe is a fixed
//   25-stage arithmetic pipe plus a 27-stage restoring divider for the
//   temperature term and a 32-stage restoring divider for the pressure
//   quotient, one quotient bit per stage. It takes one reading per cycle
//   while out_stall does not hold it. The whole pipe advances together;
//   when a result sits at the output and out_stall is high, every stage
//   holds and in_stall is raised. Reset clears all valid bits and the
//   calibration words and sets oversampling to 3; no clearing pass is needed.
// -----------------------------------------------------------------------------
module barometer_reading_compensation_unit
	import brc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        raw_temperature,
	input  logic [23:0]        raw_pressure,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] temperature_tenths,
	output logic [17:0]        pressure_pa,
	output logic [1:0]         status
);

	logic [63:0] cal_a_q;
	logic [63:0] cal_b_q;
	logic [47:0] cal_c_q;
	logic [1:0]  oss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
			oss_q   <= OSS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CAL_A: cal_a_q <= cfg_data;
				CFG_CAL_B: cal_b_q <= cfg_data;
				CFG_CAL_C: cal_c_q <= cfg_data[47:0];
				CFG_OSS:   oss_q   <= cfg_data[1:0];
				default:   ;
			endcase
		end
	end

	logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [15:0]        ac4, ac5, ac6;
	logic               bad_cal;

	assign ac1 = $signed(cal_a_q[63:48]);
	assign ac2 = $signed(cal_a_q[47:32]);
	assign ac3 = $signed(cal_a_q[31:16]);
	assign ac4 = cal_a_q[15:0];
	assign ac5 = cal_b_q[63:48];
	assign ac6 = cal_b_q[47:32];
	assign b1  = $signed(cal_b_q[31:16]);
	assign b2  = $signed(cal_b_q[15:0]);
	assign mc  = $signed(cal_c_q[31:16]);
	assign md  = $signed(cal_c_q[15:0]);

	assign bad_cal = bad_coef(cal_a_q[63:48]) || bad_coef(cal_a_q[47:32]) ||
		bad_coef(cal_a_q[31:16]) || bad_coef(cal_a_q[15:0]) ||
		bad_coef(cal_b_q[63:48]) || bad_coef(cal_b_q[47:32]) ||
		bad_coef(cal_b_q[31:16]) || bad_coef(cal_b_q[15:0]) ||
		bad_coef(cal_c_q[47:32]) || bad_coef(cal_c_q[31:16]) ||
		bad_coef(cal_c_q[15:0]);

	// global advance: the pipe holds only when the output transfer is blocked
	logic              en;
	logic [STAGES-1:0] vld_q;

	assign en       = !(vld_q[STAGES-1] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[STAGES-2:0], in_valid};
		end
	end

	// ---------------- temperature front end ----------------
	logic signed [17:0] d_s1;
	logic [18:0]        up_s1, up_s2, up_s3, up_s4;
	logic               bad_s1, bad_s2, bad_s3, bad_s4;
	logic signed [34:0] prod_s2;
	logic signed [19:0] x1_s3, x1_s4;
	logic signed [20:0] den_s4;
	logic               denz_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= $signed({2'b00, raw_temperature}) - $signed({2'b00, ac6});
			up_s1   <= 19'(raw_pressure >> (4'd8 - {2'b00, oss_q}));
			bad_s1  <= bad_cal;

			prod_s2 <= d_s1 * $signed({2'b00, ac5});
			up_s2   <= up_s1;
			bad_s2  <= bad_s1;

			x1_s3   <= 20'((prod_s2 + $signed({20'b0, {15{prod_s2[34]}}})) >>> 15);
			up_s3   <= up_s2;
			bad_s3  <= bad_s2;

			den_s4  <= 21'(x1_s3) + 21'(md);
			denz_s4 <= (21'(x1_s3) + 21'(md)) == '0;
			x1_s4   <= x1_s3;
			up_s4   <= up_s3;
			bad_s4  <= bad_s3;
		end
	end

	// ---------------- divider A: MC * 2048 / (X1 + MD) ----------------
	diva_t       dva_s [DIVA_BITS+1];
	logic [15:0] mc_mag;

	assign mc_mag = mc[15] ? 16'(-mc) : 16'(mc);

	always_ff @(posedge clk) begin
		if (en) begin
			dva_s[0].rem  <= '0;
			dva_s[0].num  <= {mc_mag, 11'b0};
			dva_s[0].dvs  <= den_s4[20] ? 20'(-den_s4) : 20'(den_s4);
			dva_s[0].neg  <= mc[15] ^ den_s4[20];
			dva_s[0].x1   <= x1_s4;
			dva_s[0].up   <= up_s4;
			dva_s[0].bad  <= bad_s4;
			dva_s[0].denz <= denz_s4;
		end
	end

	for (genvar k = 0; k < DIVA_BITS; k++) begin : g_diva
		always_ff @(posedge clk) begin
			if (en) begin
				dva_s[k+1] <= diva_step(dva_s[k]);
			end
		end
	end

	// ---------------- B5, temperature, B6 ----------------
	diva_t              da;
	logic signed [28:0] b5_s6;
	logic signed [24:0] t16_s7;
	logic signed [28:0] b6_s7;
	logic signed [28:0] tv;
	logic [15:0]        temp_s8;
	logic [27:0]        b6m_s8;
	logic signed [44:0] m2_s8, m3_s8;
	logic [18:0]        up_s6, up_s7, up_s8;
	logic               bad_s6, bad_s7, bad_s8;
	logic               denz_s6, denz_s7, denz_s8;

	assign da = dva_s[DIVA_BITS];
	assign tv = b5_s6 + 29'sd8;

	always_ff @(posedge clk) begin
		if (en) begin
			b5_s6   <= da.neg ? (29'(da.x1) - $signed({2'b00, da.num}))
			                  : (29'(da.x1) + $signed({2'b00, da.num}));
			up_s6   <= da.up;
			bad_s6  <= da.bad;
			denz_s6 <= da.denz;

			t16_s7  <= 25'((tv + $signed({25'b0, {4{tv[28]}}})) >>> 4);
			b6_s7   <= b5_s6 - $signed({17'b0, T_OFFSET});
			up_s7   <= up_s6;
			bad_s7  <= bad_s6;
			denz_s7 <= denz_s6;

			if (t16_s7 > 25'sd32767)
				temp_s8 <= 16'h7FFF;
			else if (t16_s7 < -25'sd32768)
				temp_s8 <= 16'h8000;
			else
				temp_s8 <= t16_s7[15:0];
			b6m_s8  <= b6_s7[28] ? 28'(-b6_s7) : 28'(b6_s7);
			m2_s8   <= ac2 * b6_s7;
			m3_s8   <= ac3 * b6_s7;
			up_s8   <= up_s7;
			bad_s8  <= bad_s7;
			denz_s8 <= denz_s7;
		end
	end

	// ---------------- B3 / B4 terms ----------------
	logic [27:0]        hh_s9, hl_s9, ll_s9;
	logic signed [33:0] x2a_s9;
	logic signed [31:0] x1b_s9;
	logic [43:0]        sq_s10;
	logic [55:0]        sq_full;
	logic signed [33:0] x2a_s10, x2a_s11, x2a_s12, x2a_s13;
	logic signed [31:0] x1b_s10, x1b_s11, x1b_s12, x1b_s13;
	logic signed [38:0] p2h_s11, p2l_s11, p1h_s11, p1l_s11;
	logic signed [60:0] pb2_s12, pb1_s12;
	logic signed [49:0] x1a_s13;
	logic signed [44:0] x2b_s13;
	logic signed [50:0] x3a_s14;
	logic signed [45:0] s4_s14;
	logic signed [51:0] a4;
	logic signed [54:0] v_s15;
	logic signed [43:0] x3b_s15;
	logic [31:0]        b3_s16, k_s16;
	logic [16:0]        b4_s17;
	logic [31:0]        diff_s17;
	logic [47:0]        prod4;
	logic [15:0]        temp_q [9:17];
	logic [18:0]        up_q [9:16];
	logic               bad_q [9:17];
	logic               denz_q [9:17];

	assign sq_full = {hh_s9, 28'b0} + {13'b0, hl_s9, 15'b0} + {28'b0, ll_s9};
	assign a4      = (52'(ac1) <<< 2) + 52'(x3a_s14);
	assign prod4   = {32'b0, ac4} * {16'b0, k_s16};

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s9   <= {14'b0, b6m_s8[27:14]} * {14'b0, b6m_s8[27:14]};
			hl_s9   <= {14'b0, b6m_s8[27:14]} * {14'b0, b6m_s8[13:0]};
			ll_s9   <= {14'b0, b6m_s8[13:0]} * {14'b0, b6m_s8[13:0]};
			x2a_s9  <= 34'((m2_s8 + $signed({34'b0, {11{m2_s8[44]}}})) >>> 11);
			x1b_s9  <= 32'((m3_s8 + $signed({32'b0, {13{m3_s8[44]}}})) >>> 13);

			sq_s10  <= sq_full[55:12];
			x2a_s10 <= x2a_s9;
			x1b_s10 <= x1b_s9;

			p2h_s11 <= b2 * $signed({1'b0, sq_s10[43:22]});
			p2l_s11 <= b2 * $signed({1'b0, sq_s10[21:0]});
			p1h_s11 <= b1 * $signed({1'b0, sq_s10[43:22]});
			p1l_s11 <= b1 * $signed({1'b0, sq_s10[21:0]});
			x2a_s11 <= x2a_s10;
			x1b_s11 <= x1b_s10;

			pb2_s12 <= $signed({p2h_s11, 22'b0}) + 61'(p2l_s11);
			pb1_s12 <= $signed({p1h_s11, 22'b0}) + 61'(p1l_s11);
			x2a_s12 <= x2a_s11;
			x1b_s12 <= x1b_s11;

			x1a_s13 <= 50'((pb2_s12 + $signed({50'b0, {11{pb2_s12[60]}}})) >>> 11);
			x2b_s13 <= 45'((pb1_s12 + $signed({45'b0, {16{pb1_s12[60]}}})) >>> 16);
			x2a_s13 <= x2a_s12;
			x1b_s13 <= x1b_s12;

			x3a_s14 <= 51'(x1a_s13) + 51'(x2a_s13);
			s4_s14  <= 46'(x1b_s13) + 46'(x2b_s13) + 46'sd2;

			v_s15   <= (55'(a4) <<< oss_q) + 55'sd2;
			x3b_s15 <= 44'((s4_s14 + $signed({44'b0, {2{s4_s14[45]}}})) >>> 2);

			b3_s16  <= 32'((v_s15 + $signed({53'b0, {2{v_s15[54]}}})) >>> 2);
			k_s16   <= x3b_s15[31:0] + B4_BIAS;

			b4_s17   <= prod4[31:15];
			diff_s17 <= {13'b0, up_q[16]} - b3_s16;
		end
	end

	// side-band carried along the B3/B4 section
	always_ff @(posedge clk) begin
		if (en) begin
			temp_q[9] <= temp_s8;
			up_q[9]   <= up_s8;
			bad_q[9]  <= bad_s8;
			denz_q[9] <= denz_s8;
			for (int i = 10; i <= 17; i++) begin
				temp_q[i] <= temp_q[i-1];
				bad_q[i]  <= bad_q[i-1];
				denz_q[i] <= denz_q[i-1];
			end
			for (int i = 10; i <= 16; i++) begin
				up_q[i] <= up_q[i-1];
			end
		end
	end

	// ---------------- B7 and divider B ----------------
	divb_t       dvb_s [DIVB_BITS+1];
	logic [15:0] b7_scale;
	logic [47:0] b7_full;
	logic [31:0] b7;

	assign b7_scale = 16'(B7_SCALE >> oss_q);
	assign b7_full  = {16'b0, diff_s17} * {32'b0, b7_scale};
	assign b7       = b7_full[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			dvb_s[0].rem  <= '0;
			// large B7 divides first and doubles the quotient afterwards
			dvb_s[0].num  <= b7[31] ? b7 : {b7[30:0], 1'b0};
			dvb_s[0].dvs  <= b4_s17;
			dvb_s[0].big  <= b7[31];
			dvb_s[0].temp <= temp_q[17];
			dvb_s[0].bad  <= bad_q[17];
			dvb_s[0].denz <= denz_q[17];
			dvb_s[0].b4z  <= b4_s17 == '0;
		end
	end

	for (genvar k = 0; k < DIVB_BITS; k++) begin : g_divb
		always_ff @(posedge clk) begin
			if (en) begin
				dvb_s[k+1] <= divb_step(dvb_s[k]);
			end
		end
	end

	// ---------------- pressure correction ----------------
	divb_t              db;
	logic [32:0]        q_s19;
	logic [49:0]        sqp_s20;
	logic [45:0]        m7_s20;
	logic [61:0]        t3038_s21;
	logic [29:0]        x2m_s21;
	logic signed [47:0] s_s22;
	logic signed [43:0] s16_s23;
	logic signed [47:0] pf_s24;
	logic [32:0]        q_q [20:23];
	logic [15:0]        tmp_q [19:24];
	logic [1:0]         st_q [19:24];
	logic signed [15:0] temp_out_s25;
	logic [17:0]        pres_out_s25;
	logic [1:0]         stat_out_s25;

	assign db = dvb_s[DIVB_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			q_s19     <= db.big ? {db.num, 1'b0} : {1'b0, db.num};
			tmp_q[19] <= (db.bad || db.denz) ? 16'h0000 : db.temp;
			st_q[19]  <= db.bad ? STAT_BAD_CAL :
			             (db.denz || db.b4z) ? STAT_DIV0 : STAT_OK;

			sqp_s20   <= {25'b0, q_s19[32:8]} * {25'b0, q_s19[32:8]};
			m7_s20    <= {13'b0, q_s19} * {33'b0, P_LIN_COEF};
			q_q[20]   <= q_s19;

			t3038_s21 <= {12'b0, sqp_s20} * {50'b0, P_SQ_COEF};
			x2m_s21   <= m7_s20[45:16];

			s_s22     <= $signed({2'b0, t3038_s21[61:16]}) - $signed({18'b0, x2m_s21})
			             + $signed({36'b0, P_OFFSET});

			s16_s23   <= 44'((s_s22 + $signed({44'b0, {4{s_s22[47]}}})) >>> 4);

			pf_s24    <= $signed({15'b0, q_q[23]}) + 48'(s16_s23);

			temp_out_s25 <= $signed(tmp_q[24]);
			stat_out_s25 <= st_q[24];
			if (st_q[24] != STAT_OK || pf_s24 < 48'sd0)
				pres_out_s25 <= '0;
			else if (pf_s24 > $signed({30'b0, P_MAX}))
				pres_out_s25 <= P_MAX;
			else
				pres_out_s25 <= pf_s24[17:0];

			for (int i = 20; i <= 24; i++) begin
				tmp_q[i] <= tmp_q[i-1];
				st_q[i]  <= st_q[i-1];
			end
			for (int i = 21; i <= 23; i++) begin
				q_q[i] <= q_q[i-1];
			end
		end
	end

	assign out_valid          = vld_q[STAGES-1];
	assign temperature_tenths = temp_out_s25;
	assign pressure_pa        = pres_out_s25;
	assign status             = stat_out_s25;

	// ---------------- checks ----------------
	a_bad_cal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_BAD_CAL |-> temperature_tenths == 16'sd0 && pressure_pa == '0)
		else $error("bad calibration result not zeroed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == STAT_OK || status == STAT_BAD_CAL || status == STAT_DIV0)
		else $error("undefined status code");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output stage");

	a_div0_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_DIV0 |-> pressure_pa == '0)
		else $error("zero divisor result carries pressure");

endmodule
